// ----- hw/rtl/mtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, widths, mode codes and the sRGB decode table for the mip
// texel downsampler.
// ----------------------------------------------------------------------------
package mtd_pkg;

  // Footprint and accumulator sizing.
  localparam int MaxFootprint = 9;
  localparam int CNT_W  = 4;
  localparam int CSUM_W = 21;
  localparam int ASUM_W = 12;
  localparam int MODE_W = 2;

  // Divider, square root and square widths.
  localparam int DVD_W  = 46;
  localparam int DVS_W  = 32;
  localparam int STEP_W = 6;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int MAG_W  = 21;
  localparam int SQ_W   = 43;

  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(CSUM_W);
  localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(DVD_W);

  // Filter mode codes. The unused code filters as linear.
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SRGB   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd2;

  // One finished footprint handed from the front to the back.
  typedef struct packed {
    logic [2:0][CSUM_W-1:0] csum;
    logic [ASUM_W-1:0]      asum;
    logic [CNT_W-1:0]       n;
    logic [MODE_W-1:0]      mode;
  } job_t;

  // One downsampled texel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SRCH,
    ST_PICK,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_NDIV_GO,
    ST_NDIV_WAIT,
    ST_DONE
  } bk_state_t;

  // sRGB byte to linear UNORM16.
  localparam logic [15:0] SRGB_LUT [0:255] = '{
    16'd0, 16'd20, 16'd40, 16'd60, 16'd80, 16'd99, 16'd119, 16'd139,
    16'd159, 16'd179, 16'd199, 16'd219, 16'd241, 16'd264, 16'd288, 16'd313,
    16'd340, 16'd367, 16'd396, 16'd427, 16'd458, 16'd491, 16'd526, 16'd562,
    16'd599, 16'd637, 16'd677, 16'd718, 16'd761, 16'd805, 16'd851, 16'd898,
    16'd947, 16'd997, 16'd1048, 16'd1101, 16'd1156, 16'd1212, 16'd1270, 16'd1330,
    16'd1391, 16'd1453, 16'd1517, 16'd1583, 16'd1651, 16'd1720, 16'd1790, 16'd1863,
    16'd1937, 16'd2013, 16'd2090, 16'd2170, 16'd2250, 16'd2333, 16'd2418, 16'd2504,
    16'd2592, 16'd2681, 16'd2773, 16'd2866, 16'd2961, 16'd3058, 16'd3157, 16'd3258,
    16'd3360, 16'd3464, 16'd3570, 16'd3678, 16'd3788, 16'd3900, 16'd4014, 16'd4129,
    16'd4247, 16'd4366, 16'd4488, 16'd4611, 16'd4736, 16'd4864, 16'd4993, 16'd5124,
    16'd5257, 16'd5392, 16'd5530, 16'd5669, 16'd5810, 16'd5953, 16'd6099, 16'd6246,
    16'd6395, 16'd6547, 16'd6700, 16'd6856, 16'd7014, 16'd7174, 16'd7335, 16'd7500,
    16'd7666, 16'd7834, 16'd8004, 16'd8177, 16'd8352, 16'd8528, 16'd8708, 16'd8889,
    16'd9072, 16'd9258, 16'd9445, 16'd9635, 16'd9828, 16'd10022, 16'd10219, 16'd10417,
    16'd10619, 16'd10822, 16'd11028, 16'd11235, 16'd11446, 16'd11658, 16'd11873, 16'd12090,
    16'd12309, 16'd12530, 16'd12754, 16'd12980, 16'd13209, 16'd13440, 16'd13673, 16'd13909,
    16'd14146, 16'd14387, 16'd14629, 16'd14874, 16'd15122, 16'd15371, 16'd15623, 16'd15878,
    16'd16135, 16'd16394, 16'd16656, 16'd16920, 16'd17187, 16'd17456, 16'd17727, 16'd18001,
    16'd18277, 16'd18556, 16'd18837, 16'd19121, 16'd19407, 16'd19696, 16'd19987, 16'd20281,
    16'd20577, 16'd20876, 16'd21177, 16'd21481, 16'd21787, 16'd22096, 16'd22407, 16'd22721,
    16'd23038, 16'd23357, 16'd23678, 16'd24002, 16'd24329, 16'd24658, 16'd24990, 16'd25325,
    16'd25662, 16'd26001, 16'd26344, 16'd26688, 16'd27036, 16'd27386, 16'd27739, 16'd28094,
    16'd28452, 16'd28813, 16'd29176, 16'd29542, 16'd29911, 16'd30282, 16'd30656, 16'd31033,
    16'd31412, 16'd31794, 16'd32179, 16'd32567, 16'd32957, 16'd33350, 16'd33745, 16'd34143,
    16'd34544, 16'd34948, 16'd35355, 16'd35764, 16'd36176, 16'd36591, 16'd37008, 16'd37429,
    16'd37852, 16'd38278, 16'd38706, 16'd39138, 16'd39572, 16'd40009, 16'd40449, 16'd40891,
    16'd41337, 16'd41785, 16'd42236, 16'd42690, 16'd43147, 16'd43606, 16'd44069, 16'd44534,
    16'd45002, 16'd45473, 16'd45947, 16'd46423, 16'd46903, 16'd47385, 16'd47871, 16'd48359,
    16'd48850, 16'd49344, 16'd49841, 16'd50341, 16'd50844, 16'd51349, 16'd51858, 16'd52369,
    16'd52884, 16'd53401, 16'd53921, 16'd54445, 16'd54971, 16'd55500, 16'd56032, 16'd56567,
    16'd57105, 16'd57646, 16'd58190, 16'd58737, 16'd59287, 16'd59840, 16'd60396, 16'd60955,
    16'd61517, 16'd62082, 16'd62650, 16'd63221, 16'd63795, 16'd64372, 16'd64952, 16'd65535
  };

endpackage

// ----- hw/rtl/mtd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_front
// Accumulates the texels of one footprint and hands the finished sums to
// the back end as one job.
// ----------------------------------------------------------------------------
module mtd_front import mtd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [7:0]        alpha,
  input  logic              last,
  input  logic [MODE_W-1:0] mode,
  output logic              job_push,
  output job_t              job
);

  logic [2:0][CSUM_W-1:0] csum_r, csum_nxt;
  logic [ASUM_W-1:0]      asum_r, asum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [2:0][7:0]        bytes;
  logic [2:0][CSUM_W-1:0] addend;

  assign bytes = {blue, green, red};

  // Per-channel addend: decoded table value in sRGB mode, raw byte otherwise.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      addend[c] = (mode == MODE_SRGB) ? CSUM_W'(SRGB_LUT[bytes[c]]) : CSUM_W'(bytes[c]);
    end
  end

  // Sums with the current texel folded in; a full footprint ignores more texels.
  always_comb begin
    csum_nxt = csum_r;
    asum_nxt = asum_r;
    cnt_nxt  = cnt_r;
    if (cnt_r < CNT_W'(MaxFootprint)) begin
      for (int c = 0; c < 3; c++) begin
        csum_nxt[c] = csum_r[c] + addend[c];
      end
      asum_nxt = asum_r + ASUM_W'(alpha);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
  end

  assign job_push  = accept && last;
  assign job.csum  = csum_nxt;
  assign job.asum  = asum_nxt;
  assign job.n     = cnt_nxt;
  assign job.mode  = mode;

  // Accumulators clear once the footprint is handed over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r <= '0;
      asum_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      if (last) begin
        csum_r <= '0;
        asum_r <= '0;
        cnt_r  <= '0;
      end else begin
        csum_r <= csum_nxt;
        asum_r <= asum_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

// ----- hw/rtl/mtd_job_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_job_queue
// Two-entry queue of finished footprints between the front and the back end.
// ----------------------------------------------------------------------------
module mtd_job_queue import mtd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  // Storage is written only on a push transfer.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ----- hw/rtl/mtd_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_divider
// Restoring divider, one quotient bit per cycle. The dividend is taken from
// its top bits, so a short division loads its value left-aligned and runs
// fewer steps.
// ----------------------------------------------------------------------------
module mtd_divider import mtd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r, quo_r;
  logic [DVS_W-1:0]  dvs_r, rem_r;
  logic [DVS_W:0]    rem_sh, rem_sub;
  logic              ge;

  // One trial subtraction per cycle.
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  assign done     = done_r;
  assign quotient = quo_r;

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/mtd_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mtd_isqrt import mtd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic             busy_r, done_r;
  logic [RAD_W-1:0] v_r, root_r, probe_r;
  logic [RAD_W-1:0] trial;
  logic             ge;

  assign trial = root_r + probe_r;
  assign ge    = v_r >= trial;
  assign done  = done_r;
  assign root  = root_r[ROOT_W-1:0];

  // Control: the probe walks down two bits a cycle until it reaches one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && probe_r == RAD_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Digit-by-digit datapath.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      v_r     <= radicand;
      root_r  <= '0;
      probe_r <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy_r) begin
      if (ge) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + probe_r;
      end else begin
        root_r <= root_r >> 1;
      end
      probe_r <= probe_r >> 2;
    end
  end

endmodule

// ----- hw/rtl/mtd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_back
// Sequencer that turns one footprint job into one texel: rounded means,
// sRGB re-encode search, and normal-vector renormalization.
// ----------------------------------------------------------------------------
module mtd_back import mtd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   job_empty,
  input  job_t   job_in,
  output logic   job_pop,
  output logic   res_valid,
  input  logic   res_take,
  output texel_t res
);

  bk_state_t         state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [3:0][7:0]   chan_r, chan_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [ROOT_W-1:0] len_r, len_nxt;
  logic [15:0]       lin_r, lin_nxt;
  logic [7:0]        idx_r, idx_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic              neg_r, neg_nxt;

  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [DVS_W-1:0]  div_dvs;
  logic [STEP_W-1:0] div_steps;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  logic [CSUM_W-1:0] sum_sel, mean_num;
  logic [11:0]       n255;
  logic [22:0]       s_val;
  logic              s_neg;
  logic [22:0]       s_abs;
  logic [MAG_W-1:0]  s_mag;
  logic [2*MAG_W-1:0] s_sq;
  logic [28:0]       mag255;
  logic [DVD_W-1:0]  norm_dvd;
  logic [7:0]        srch_t, pick_lo_idx;
  logic [15:0]       pick_lo, pick_hi;
  logic [7:0]        norm_v;
  logic [8:0]        qm;
  logic              qbig;
  logic              is_normal;

  // Sum for the channel in work; the fourth channel is alpha.
  always_comb begin
    case (ch_r)
      2'd0:    sum_sel = job_r.csum[0];
      2'd1:    sum_sel = job_r.csum[1];
      2'd2:    sum_sel = job_r.csum[2];
      default: sum_sel = CSUM_W'(job_r.asum);
    endcase
  end

  assign mean_num = sum_sel + CSUM_W'(job_r.n >> 1);

  // Signed normal component 2*sum - 255*n and its magnitude.
  assign n255   = {job_r.n, 8'b0} - {8'b0, job_r.n};
  assign s_val  = {1'b0, sum_sel, 1'b0} - {11'b0, n255};
  assign s_neg  = s_val[22];
  assign s_abs  = s_neg ? (23'd0 - s_val) : s_val;
  assign s_mag  = s_abs[MAG_W-1:0];
  assign s_sq   = s_mag * s_mag;
  assign mag255 = {s_mag, 8'b0} - {8'b0, s_mag};
  assign norm_dvd = {1'b0, mag255, 16'b0} + DVD_W'(len_r[ROOT_W-1:1]);

  // Divider operand select.
  assign div_dvd   = (state_r == ST_NDIV_GO) ? norm_dvd : {mean_num, 25'b0};
  assign div_dvs   = (state_r == ST_NDIV_GO) ? len_r : DVS_W'(job_r.n);
  assign div_steps = (state_r == ST_NDIV_GO) ? NORM_STEPS : MEAN_STEPS;

  // Table index probe for the re-encode search.
  assign srch_t      = idx_r | (8'd1 << bit_r);
  assign pick_lo_idx = idx_r - 8'd1;
  assign pick_lo     = SRGB_LUT[pick_lo_idx];
  assign pick_hi     = SRGB_LUT[idx_r];

  // Normal output byte: (q + 256) / 2, clamped to a byte.
  assign qbig = |div_quo[DVD_W-1:9];
  assign qm   = div_quo[8:0];
  always_comb begin
    if (neg_r) begin
      if (qbig || qm >= 9'd256) norm_v = 8'd0;
      else                      norm_v = 8'((9'd256 - qm) >> 1);
    end else begin
      if (qbig || qm >= 9'd255) norm_v = 8'd255;
      else                      norm_v = 8'(({1'b0, qm} + 10'd256) >> 1);
    end
  end

  assign is_normal = (job_r.mode == MODE_NORMAL);

  // Next state and datapath updates.
  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    ch_nxt     = ch_r;
    chan_nxt   = chan_r;
    sq_nxt     = sq_r;
    len_nxt    = len_r;
    lin_nxt    = lin_r;
    idx_nxt    = idx_r;
    bit_nxt    = bit_r;
    neg_nxt    = neg_r;
    job_pop    = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          job_nxt   = job_in;
          ch_nxt    = 2'd0;
          sq_nxt    = '0;
          state_nxt = (job_in.mode == MODE_NORMAL) ? ST_SQ : ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        div_start = 1'b1;
        state_nxt = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          if (job_r.mode == MODE_SRGB && ch_r != 2'd3) begin
            lin_nxt   = div_quo[15:0];
            idx_nxt   = 8'd0;
            bit_nxt   = 3'd7;
            state_nxt = ST_SRCH;
          end else begin
            chan_nxt[ch_r] = div_quo[7:0];
            if (ch_r == 2'd3) begin
              state_nxt = ST_DONE;
            end else begin
              ch_nxt    = ch_r + 2'd1;
              state_nxt = ST_MEAN_GO;
            end
          end
        end
      end
      ST_SRCH: begin
        // Count the table entries below the linear value, MSB first.
        if (SRGB_LUT[srch_t - 8'd1] < lin_r) idx_nxt = srch_t;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        // Nearest of the two neighbors, ties to the lower index.
        if (idx_r == 8'd0) begin
          chan_nxt[ch_r] = 8'd0;
        end else if ((lin_r - pick_lo) <= (pick_hi - lin_r)) begin
          chan_nxt[ch_r] = pick_lo_idx;
        end else begin
          chan_nxt[ch_r] = idx_r;
        end
        ch_nxt    = ch_r + 2'd1;
        state_nxt = ST_MEAN_GO;
      end
      ST_SQ: begin
        sq_nxt = sq_r + SQ_W'(s_sq);
        if (ch_r == 2'd2) begin
          ch_nxt    = 2'd0;
          state_nxt = ST_SQRT_GO;
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      ST_SQRT_GO: begin
        if (sq_r == '0) begin
          // Zero vector: straight up.
          chan_nxt[0] = 8'd128;
          chan_nxt[1] = 8'd128;
          chan_nxt[2] = 8'd255;
          ch_nxt      = 2'd3;
          state_nxt   = ST_MEAN_GO;
        end else begin
          sqrt_start = 1'b1;
          state_nxt  = ST_SQRT_WAIT;
        end
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          len_nxt   = sqrt_root;
          ch_nxt    = 2'd0;
          state_nxt = ST_NDIV_GO;
        end
      end
      ST_NDIV_GO: begin
        div_start = 1'b1;
        neg_nxt   = s_neg;
        state_nxt = ST_NDIV_WAIT;
      end
      ST_NDIV_WAIT: begin
        if (div_done) begin
          chan_nxt[ch_r] = norm_v;
          ch_nxt         = ch_r + 2'd1;
          state_nxt      = (is_normal && ch_r != 2'd2) ? ST_NDIV_GO : ST_MEAN_GO;
        end
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Working registers.
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    ch_r   <= ch_nxt;
    chan_r <= chan_nxt;
    sq_r   <= sq_nxt;
    len_r  <= len_nxt;
    lin_r  <= lin_nxt;
    idx_r  <= idx_nxt;
    bit_r  <= bit_nxt;
    neg_r  <= neg_nxt;
  end

  assign res_valid = (state_r == ST_DONE);
  assign res.red   = chan_r[0];
  assign res.green = chan_r[1];
  assign res.blue  = chan_r[2];
  assign res.alpha = chan_r[3];

  mtd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  mtd_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({sq_r[31:0], 32'b0}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

endmodule

// ----- hw/rtl/mip_texel_downsample_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_texel_downsample_core
// Box-filter mipmap downsampler for RGBA8 texels with linear, sRGB and
// normal-map modes.
// ----------------------------------------------------------------------------
// The front end takes one texel per cycle while the job queue has room
// and adds it into the footprint sums; a texel with in_last_texel set
// closes the footprint and passes it to a two-entry job queue, and
// in_full is high while that queue is full. The back end works one
// footprint at a time with a shared restoring divider (one bit per cycle)
// and a square root: a rounded mean per channel in linear mode, with an
// eight-step table search and a pick per color in sRGB mode, and squares,
// the root and a division per component in normal mode. The finished texel
// waits in an output register while the back end starts the next footprint.
// ----------------------------------------------------------------------------
module mip_texel_downsample_core import mtd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_alpha_in,
  input  logic       in_last_texel,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [7:0] out_alpha_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_filter_mode
);

  logic [MODE_W-1:0] mode_r;
  logic              in_xfer;
  logic              fe_push;
  job_t              fe_job;
  logic              jq_full, jq_empty, bk_pop;
  job_t              jq_job;
  logic              bk_res_valid, out_load;
  texel_t            bk_res;
  logic              out_valid_r;
  texel_t            out_data_r;

  // Filter mode register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)         mode_r <= MODE_LINEAR;
    else if (cfg_valid) mode_r <= cfg_filter_mode;
  end

  assign in_full = jq_full;
  assign in_xfer = in_push && !jq_full;

  mtd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_xfer),
    .red      (in_red_in),
    .green    (in_green_in),
    .blue     (in_blue_in),
    .alpha    (in_alpha_in),
    .last     (in_last_texel),
    .mode     (mode_r),
    .job_push (fe_push),
    .job      (fe_job)
  );

  mtd_job_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .wdata (fe_job),
    .full  (jq_full),
    .pop   (bk_pop),
    .rdata (jq_job),
    .empty (jq_empty)
  );

  mtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (jq_empty),
    .job_in    (jq_job),
    .job_pop   (bk_pop),
    .res_valid (bk_res_valid),
    .res_take  (out_load),
    .res       (bk_res)
  );

  // Output register: refilled when empty or on the cycle it is popped.
  assign out_load = bk_res_valid && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= bk_res;
  end

  assign out_empty     = !out_valid_r;
  assign out_red_out   = out_data_r.red;
  assign out_green_out = out_data_r.green;
  assign out_blue_out  = out_data_r.blue;
  assign out_alpha_out = out_data_r.alpha;

  // A footprint is never handed to a full job queue.
  assert property (@(posedge clk) disable iff (!rst_n) fe_push |-> !jq_full)
    else $error("job pushed into full queue");

  // The back end only takes a job that is there.
  assert property (@(posedge clk) disable iff (!rst_n) bk_pop |-> !jq_empty)
    else $error("job popped from empty queue");

  // A pop with no refill leaves the result side empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_load) |=> out_empty)
    else $error("result still shown after its transfer");

endmodule

// ----- tb/mip_texel_downsample_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_texel_downsample_checker
// Watches the texel, result and mode channels of the mip texel downsampler.
// It keeps its own footprint sums, predicts each downsampled texel when a
// footprint closes and compares every popped result with the oldest one.
// ----------------------------------------------------------------------------
module mip_texel_downsample_checker import mtd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_alpha_in,
  input  logic       in_last_texel,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [7:0] out_red_out,
  input  logic [7:0] out_green_out,
  input  logic [7:0] out_blue_out,
  input  logic [7:0] out_alpha_out,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_filter_mode,
  output int         error_count,
  output int         texels_awaited,
  output int         texels_checked
);

  // Model copy of the block's configuration and footprint state.
  logic [MODE_W-1:0] mode_q;
  logic [CSUM_W-1:0] chan_sum [3];
  logic [ASUM_W-1:0] alpha_acc;
  logic [CNT_W-1:0]  texel_cnt;
  texel_t            downsampled_q [$];

  // Integer square root, one result bit per pair of radicand bits.
  function automatic logic [63:0] root_of(logic [63:0] radicand);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > radicand) probe = probe >> 2;
    while (probe != 0) begin
      if (radicand >= root + probe) begin
        radicand = radicand - (root + probe);
        root     = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Nearest sRGB code for a linear UNORM16 value; ties go to the lower code.
  function automatic logic [7:0] srgb_code(int unsigned lin);
    int i;
    i = 0;
    while (i < 256 && int'(SRGB_LUT[i]) < lin) i++;
    if (i == 0) return 8'd0;
    if (i == 256) return 8'd255;
    if (lin - SRGB_LUT[i-1] <= SRGB_LUT[i] - lin) return 8'(i - 1);
    return 8'(i);
  endfunction

  function automatic int unsigned round_mean(int unsigned total, int unsigned n);
    return (total + n / 2) / n;
  endfunction

  // Downsampled texel for the current sums, interpreted per the current mode.
  function automatic texel_t footprint_texel();
    texel_t      t;
    int unsigned n;
    longint      s [3];
    longint      sq;
    longint      len;
    longint      num;
    longint      q;
    longint      v;
    logic [7:0]  c [3];
    n = (texel_cnt == 0) ? 1 : texel_cnt;
    if (mode_q == MODE_NORMAL) begin
      for (int k = 0; k < 3; k++) s[k] = 2 * longint'(chan_sum[k]) - 255 * longint'(n);
      sq = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
      if (sq == 0) begin
        c[0] = 8'd128; c[1] = 8'd128; c[2] = 8'd255;
      end else begin
        len = longint'(root_of(64'(sq) << 32));
        for (int k = 0; k < 3; k++) begin
          num = s[k] * 255 * 65536;
          q = (num >= 0) ? (num + len / 2) / len : -((-num + len / 2) / len);
          v = (q + 256) / 2;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          c[k] = 8'(v);
        end
      end
    end else if (mode_q == MODE_SRGB) begin
      for (int k = 0; k < 3; k++) c[k] = srgb_code(round_mean(chan_sum[k], n));
    end else begin
      for (int k = 0; k < 3; k++) c[k] = 8'(round_mean(chan_sum[k], n));
    end
    t.red   = c[0];
    t.green = c[1];
    t.blue  = c[2];
    t.alpha = 8'(round_mean(alpha_acc, n));
    return t;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  initial begin
    error_count    = 0;
    texels_checked = 0;
    texels_awaited = 0;
  end

  // Track every transfer on the three channels at the clock edge.
  always @(posedge clk) begin
    texel_t     want;
    logic [7:0] b [3];
    if (!rst_n) begin
      mode_q    = MODE_LINEAR;
      alpha_acc = '0;
      texel_cnt = '0;
      for (int k = 0; k < 3; k++) chan_sum[k] = '0;
      downsampled_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (downsampled_q.size() == 0) begin
          $display("%0t result transfer with no texel expected", $time);
          error_count++;
        end else begin
          want = downsampled_q.pop_front();
          if (out_red_out !== want.red) report_mismatch("red", out_red_out, want.red);
          if (out_green_out !== want.green)
            report_mismatch("green", out_green_out, want.green);
          if (out_blue_out !== want.blue) report_mismatch("blue", out_blue_out, want.blue);
          if (out_alpha_out !== want.alpha)
            report_mismatch("alpha", out_alpha_out, want.alpha);
          texels_checked++;
        end
      end
      if (in_push && !in_full) begin
        b[0] = in_red_in; b[1] = in_green_in; b[2] = in_blue_in;
        // Texels past a full footprint are dropped but the last flag still closes it.
        if (texel_cnt < MaxFootprint) begin
          for (int k = 0; k < 3; k++)
            chan_sum[k] = chan_sum[k] + ((mode_q == MODE_SRGB) ? SRGB_LUT[b[k]] : b[k]);
          alpha_acc = alpha_acc + in_alpha_in;
          texel_cnt = texel_cnt + 1'b1;
        end
        if (in_last_texel) begin
          downsampled_q.insert(downsampled_q.size(), footprint_texel());
          alpha_acc = '0;
          texel_cnt = '0;
          for (int k = 0; k < 3; k++) chan_sum[k] = '0;
        end
      end
      if (cfg_valid && cfg_ready) mode_q = cfg_filter_mode;
    end
    texels_awaited = downsampled_q.size();
  end

endmodule

// ----- tb/mip_texel_downsample_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_texel_downsample_core_test
// Streams directed and random texel footprints through the downsampler in
// every filter mode, with random gaps on both sides and a long result stall.
// ----------------------------------------------------------------------------
module mip_texel_downsample_core_test;
  import mtd_pkg::*;

  localparam int TexelTarget = 1050;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 300;

  // The spare mode code, which filters as linear.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_red_in;
  logic [7:0] in_green_in;
  logic [7:0] in_blue_in;
  logic [7:0] in_alpha_in;
  logic       in_last_texel;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic [7:0] out_alpha_out;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_filter_mode;
  int         error_count;
  int         texels_awaited;
  int         texels_checked;
  int         texels_sent;
  int         cycle_cnt;

  mip_texel_downsample_core u_top (.*);

  mip_texel_downsample_checker u_checker (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A run that stops making progress ends here.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stalls, and one long hold-off so the job queue fills.
  initial begin
    int stall;
    int popped;
    bit held;
    out_pop = 1'b0;
    stall   = 0;
    popped  = 0;
    held    = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) popped++;
      if (!held && popped >= 30) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (3000) @(posedge clk);
        out_pop <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else begin
        stall = pick_gap();
        out_pop <= (stall == 0);
      end
    end
  end

  // One texel transfer, optionally followed by an idle gap.
  task automatic send_texel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                            logic last, int gap);
    in_red_in     <= r;
    in_green_in   <= g;
    in_blue_in    <= b;
    in_alpha_in   <= a;
    in_last_texel <= last;
    in_push       <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    texels_sent++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Footprint of one repeated texel.
  task automatic send_flat(int n, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] a);
    for (int i = 0; i < n; i++) send_texel(r, g, b, a, i == n - 1, 0);
  endtask

  // Mode write once every result has come and the back end has gone quiet.
  task automatic set_mode(logic [1:0] mode);
    in_push <= 1'b0;
    @(posedge clk);
    while (texels_awaited != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_filter_mode <= mode;
    cfg_valid       <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random footprint: mostly the usual sizes, sometimes past the maximum.
  task automatic send_random_footprint();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) n = 1;
    else if (r < 60) n = 4;
    else if (r < 90) n = $urandom_range(2, 9);
    else n = $urandom_range(10, 13);
    for (int i = 0; i < n; i++)
      send_texel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), i == n - 1, pick_gap());
  endtask

  // Stimulus and verdict.
  initial begin
    logic [1:0] mode_seq [8];
    mode_seq = '{MODE_LINEAR, MODE_SRGB, MODE_NORMAL, MODE_SPARE,
                 MODE_NORMAL, MODE_SRGB, MODE_LINEAR, MODE_NORMAL};
    texels_sent     = 0;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_red_in       = '0;
    in_green_in     = '0;
    in_blue_in      = '0;
    in_alpha_in     = '0;
    in_last_texel   = 1'b0;
    cfg_valid       = 1'b0;
    cfg_filter_mode = MODE_LINEAR;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, saturated footprint and overflow in linear mode.
    send_flat(1, 8'd0, 8'd0, 8'd0, 8'd0);
    send_flat(1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_flat(9, 8'd255, 8'd255, 8'd255, 8'd255);
    send_flat(12, 8'd1, 8'd128, 8'd254, 8'd3);
    // sRGB averaging of black and white.
    set_mode(MODE_SRGB);
    send_texel(8'd0, 8'd255, 8'd10, 8'd0, 1'b0, 0);
    send_texel(8'd255, 8'd0, 8'd200, 8'd255, 1'b1, 0);
    send_flat(9, 8'd255, 8'd255, 8'd255, 8'd255);
    // Normal mode: an opposite pair that sums to a zero vector, a single texel and a full footprint.
    set_mode(MODE_NORMAL);
    send_texel(8'd127, 8'd128, 8'd127, 8'd9, 1'b0, 0);
    send_texel(8'd128, 8'd127, 8'd128, 8'd10, 1'b1, 0);
    send_flat(1, 8'd0, 8'd0, 8'd0, 8'd0);
    send_flat(9, 8'd128, 8'd128, 8'd255, 8'd255);
    // The spare mode code filters as linear.
    set_mode(MODE_SPARE);
    send_flat(3, 8'd100, 8'd7, 8'd255, 8'd1);

    // Random phases cycling through all modes.
    for (int p = 0; texels_sent < TexelTarget; p++) begin
      set_mode(mode_seq[p % 8]);
      for (int f = 0; f < 30 && texels_sent < TexelTarget; f++) send_random_footprint();
    end
    in_push <= 1'b0;

    // Drain.
    @(posedge clk);
    while (texels_awaited != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d texels in all four mode settings, including overflowing footprints.",
             texels_sent);
    $display("Checked %0d downsampled texels with random stalls on both sides.",
             texels_checked);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_front.sv
hw/rtl/mtd_job_queue.sv
hw/rtl/mtd_divider.sv
hw/rtl/mtd_isqrt.sv
hw/rtl/mtd_back.sv
hw/rtl/mip_texel_downsample_core.sv
tb/mip_texel_downsample_checker.sv
tb/mip_texel_downsample_core_test.sv
